// ----- rtl/core/pvo_pkg.sv -----
`default_nettype none
package pvo_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int COORD_WIDTH = 32;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int SUM_W       = COORD_WIDTH + IDX_W;
    localparam int PROD_W      = COORD_WIDTH + CNT_W + 1;

    // input item
    typedef struct packed {
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic               last_point;
    } point_t;

    // result item
    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               out_last;
        logic               overflow;
    } result_t;

    // classified item handed from front to back
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic                          keep;
        logic                          last;
        logic [CNT_W-1:0]              count;
        logic signed [SUM_W-1:0]       sum;
        logic                          dropped;
    } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/pvo_front.sv -----
`default_nettype none
module pvo_front
    import pvo_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   point_valid,
    output logic        point_stall,
    input  wire point_t point,
    input  wire logic   q_full,
    output logic        push,
    output cmd_t        cmd
);

    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    drop_reg, drop_next;
    logic signed [COORD_WIDTH-1:0] x_val, y_val;

    assign point_stall = q_full;
    assign push        = point_valid && !q_full;
    assign x_val       = point.x_coord[COORD_WIDTH-1:0];
    assign y_val       = point.y_coord[COORD_WIDTH-1:0];

    // classify the point: store or drop, and running totals
    always_comb
    begin
        cmd.x       = x_val;
        cmd.y       = y_val;
        cmd.last    = point.last_point;
        cmd.keep    = (count_reg < CNT_W'(MAX_POINTS));
        cmd.count   = cmd.keep ? count_reg + CNT_W'(1) : count_reg;
        cmd.sum     = cmd.keep ? sum_reg + SUM_W'(y_val) : sum_reg;
        cmd.dropped = drop_reg || !cmd.keep;
        count_next  = count_reg;
        sum_next    = sum_reg;
        drop_next   = drop_reg;
        if (push)
        begin
            if (point.last_point)
            begin
                count_next = '0;
                sum_next   = '0;
                drop_next  = 1'b0;
            end
            else
            begin
                count_next = cmd.count;
                sum_next   = cmd.sum;
                drop_next  = cmd.dropped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            drop_reg  <= drop_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/pvo_queue.sv -----
`default_nettype none
module pvo_queue
    import pvo_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      head
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/pvo_back.sv -----
`default_nettype none
module pvo_back
    import pvo_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  wire cmd_t q_head,
    output logic      pop,
    output logic      result_valid,
    input  wire logic result_stall,
    output result_t   result
);

    typedef enum logic [1:0] {S_LOAD, S_COPY, S_READ, S_CHECK} state_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic                          low;
    } entry_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        n_reg, k_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    drop_reg;
    logic [IDX_W-1:0]        copy_idx_reg, idx_reg;
    logic                    pass_reg;
    logic                    out_valid_reg;
    result_t                 out_data_reg;
    entry_t                  rd_reg;
    entry_t                  mem [MAX_POINTS];

    logic signed [COORD_WIDTH-1:0] cell_x [MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] cell_y [MAX_POINTS];
    logic [MAX_POINTS-1:0]         cell_v;
    logic [MAX_POINTS-1:0]         sel;
    logic                          insert, shift_out;
    logic signed [PROD_W-1:0]      prod;
    logic                          low;
    logic                          emit, out_free;

    assign pop          = q_valid && (state_reg == S_LOAD);
    assign insert       = pop && q_head.keep;
    assign shift_out    = (state_reg == S_COPY);
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // exact mean test on the head of the chain
    assign prod = PROD_W'(cell_y[0]) * $signed({1'b0, n_reg});
    assign low  = prod <= PROD_W'(sum_reg);

    assign emit     = pass_reg ? !rd_reg.low : rd_reg.low;
    assign out_free = !out_valid_reg || !result_stall;

    // cells whose x exceeds the new x, or empty cells
    always_comb
    begin
        for (int i = 0; i < MAX_POINTS; i++)
            sel[i] = !cell_v[i] || (cell_x[i] > q_head.x);
    end

    // sorting chain payload: stable insert, or shift toward the head
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            if (insert)
            begin
                if (i > 0 && sel[i-1])
                begin
                    cell_x[i] <= cell_x[i-1];
                    cell_y[i] <= cell_y[i-1];
                end
                else if (sel[i])
                begin
                    cell_x[i] <= q_head.x;
                    cell_y[i] <= q_head.y;
                end
            end
            else if (shift_out && i < MAX_POINTS - 1)
            begin
                cell_x[i] <= cell_x[i+1];
                cell_y[i] <= cell_y[i+1];
            end
        end
    end

    // sorting chain occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_v <= '0;
        else if (insert)
            cell_v <= {cell_v[MAX_POINTS-2:0], 1'b1};
        else if (shift_out)
            cell_v <= {1'b0, cell_v[MAX_POINTS-1:1]};
    end

    // sorted point memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_COPY)
            mem[copy_idx_reg] <= '{x: cell_x[0], y: cell_y[0], low: low};
        if (state_reg == S_READ)
            rd_reg <= mem[idx_reg];
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            n_reg         <= '0;
            k_reg         <= '0;
            sum_reg       <= '0;
            drop_reg      <= 1'b0;
            copy_idx_reg  <= '0;
            idx_reg       <= '0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (!result_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (pop && q_head.last)
                    begin
                        n_reg        <= q_head.count;
                        sum_reg      <= q_head.sum;
                        drop_reg     <= q_head.dropped;
                        copy_idx_reg <= '0;
                        state_reg    <= S_COPY;
                    end
                end
                S_COPY:
                begin
                    copy_idx_reg <= copy_idx_reg + IDX_W'(1);
                    if (CNT_W'(copy_idx_reg) + CNT_W'(1) == n_reg)
                    begin
                        idx_reg   <= '0;
                        pass_reg  <= 1'b0;
                        k_reg     <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (!emit || out_free)
                    begin
                        if (emit)
                        begin
                            out_valid_reg         <= 1'b1;
                            out_data_reg.out_x    <= 32'(rd_reg.x);
                            out_data_reg.out_y    <= 32'(rd_reg.y);
                            out_data_reg.out_last <= (k_reg + CNT_W'(1) == n_reg);
                            out_data_reg.overflow <= drop_reg;
                            k_reg                 <= k_reg + CNT_W'(1);
                        end
                        state_reg <= S_READ;
                        if (!pass_reg)
                        begin
                            if (CNT_W'(idx_reg) + CNT_W'(1) == n_reg)
                                pass_reg <= 1'b1;
                            else
                                idx_reg <= idx_reg + IDX_W'(1);
                        end
                        else if (idx_reg == '0)
                            state_reg <= S_LOAD;
                        else
                            idx_reg <= idx_reg - IDX_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/polygon_vertex_ordering.sv -----
`default_nettype none
// Orders the points of one set for polygon drawing. Points are taken one per
// transfer and pass through a two-entry queue into a sorting chain, which
// takes one point per cycle while the back end is loading, so loading runs
// near one point per cycle; while a set is copied or emitted the chain takes
// no points and the queue stalls the input once it is full. When the point
// marked last_point arrives, the chain is copied into a memory point by
// point, and the points are then emitted: first those with y at or below
// the mean in ascending x, then the rest in descending x. Each point is
// visited once in each of the two passes, and each visit is a memory read
// followed by the check; emission waits while the receiver stalls the output.
// Points beyond 64 are dropped and every result of that set shows overflow.
module polygon_vertex_ordering
    import pvo_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    point_valid,
    output logic         point_stall,
    input  wire point_t  point,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    logic q_full, q_push, q_pop, q_valid;
    cmd_t q_in, q_head;

    pvo_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .q_full      (q_full),
        .push        (q_push),
        .cmd         (q_in)
    );

    pvo_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    pvo_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import pvo_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    point_valid;
    logic    point_stall;
    point_t  point;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    polygon_vertex_ordering dut (
        .clk(clk),
        .rst_n(rst_n),
        .point_valid(point_valid),
        .point_stall(point_stall),
        .point(point),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    // predictor state: points of the current set
    logic signed [31:0] set_x [$];
    logic signed [31:0] set_y [$];
    logic               set_dropped;
    result_t            ordered_queue [$];

    int  error_count;
    int  hold_cycles;
    bit  rx_idle_on;
    bit  tx_idle_on;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    task automatic report_mismatch(input string what);
        begin
            error_count++;
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    // order the finished set: low points ascending x, then high points descending
    task automatic order_set();
        int                  order_idx [64];
        bit                  is_low [64];
        int                  n;
        int                  i;
        int                  j;
        int                  k;
        int                  cur;
        logic signed [37:0]  sum;
        logic signed [45:0]  prod;
        result_t             r;
        begin
            n = set_x.size();
            sum = '0;
            for (i = 0; i < n; i++)
                sum += 38'(set_y[i]);
            // stable insertion sort by x
            for (i = 0; i < n; i++)
            begin
                cur = i;
                j = i;
                while (j > 0 && set_x[order_idx[j-1]] > set_x[cur])
                begin
                    order_idx[j] = order_idx[j-1];
                    j--;
                end
                order_idx[j] = cur;
            end
            for (i = 0; i < n; i++)
            begin
                prod = 46'(set_y[order_idx[i]]) * 46'(n);
                is_low[i] = (prod <= 46'(sum));
            end
            k = 0;
            for (i = 0; i < n; i++)
                if (is_low[i])
                begin
                    r.out_x = set_x[order_idx[i]];
                    r.out_y = set_y[order_idx[i]];
                    r.out_last = (k + 1 == n);
                    r.overflow = set_dropped;
                    ordered_queue = {ordered_queue, r};
                    k++;
                end
            for (i = n - 1; i >= 0; i--)
                if (!is_low[i])
                begin
                    r.out_x = set_x[order_idx[i]];
                    r.out_y = set_y[order_idx[i]];
                    r.out_last = (k + 1 == n);
                    r.overflow = set_dropped;
                    ordered_queue = {ordered_queue, r};
                    k++;
                end
            set_x.delete();
            set_y.delete();
            set_dropped = 1'b0;
        end
    endtask

    task automatic predict_point(input point_t p);
        begin
            if (set_x.size() < MAX_POINTS)
            begin
                set_x = {set_x, p.x_coord};
                set_y = {set_y, p.y_coord};
            end
            else
                set_dropped = 1'b1;
            if (p.last_point)
                order_set();
        end
    endtask

    // send one point, with a random gap first when tx_idle_on is set; valid stays
    // high after the transfer so that back-to-back points need only one assignment per edge
    task automatic send_point(input logic [31:0] x, input logic [31:0] y, input bit last);
        int gap;
        point_t p;
        begin
            gap = tx_idle_on ? $urandom_range(0, 17) : 0;
            if (gap > 0)
            begin
                point_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            p.x_coord = x;
            p.y_coord = y;
            p.last_point = last;
            point <= p;
            point_valid <= 1'b1;
            @(posedge clk);
            while (point_stall) @(posedge clk);
            predict_point(p);
        end
    endtask

    function automatic logic [31:0] rand_coord();
        int sel;
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: rand_coord = 32'h8000_0000;
                1: rand_coord = 32'h7fff_ffff;
                2: rand_coord = 32'($urandom_range(0, 7)) - 32'd3;
                3, 4: rand_coord = 32'($urandom_range(0, 15)) << 16;
                default: rand_coord = $urandom;
            endcase
        end
    endfunction

    task automatic send_set(input int n);
        int i;
        begin
            for (i = 0; i < n; i++)
                send_point(rand_coord(), rand_coord(), i == n - 1);
        end
    endtask

    task automatic wait_drained();
        begin
            point_valid <= 1'b0;
            while (ordered_queue.size() != 0) @(posedge clk);
            repeat (20) @(posedge clk);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && result_valid && !result_stall)
        begin
            if (ordered_queue.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                exp_r = ordered_queue.pop_front();
                if (result.out_x !== exp_r.out_x)
                    report_mismatch($sformatf("out_x %h exp %h", result.out_x, exp_r.out_x));
                if (result.out_y !== exp_r.out_y)
                    report_mismatch($sformatf("out_y %h exp %h", result.out_y, exp_r.out_y));
                if (result.out_last !== exp_r.out_last)
                    report_mismatch($sformatf("out_last %b exp %b",
                                              result.out_last, exp_r.out_last));
                if (result.overflow !== exp_r.overflow)
                    report_mismatch($sformatf("overflow %b exp %b",
                                              result.overflow, exp_r.overflow));
            end
        end
    end

    // receiver stall: random per result, or a long hold-off
    initial
    begin
        int n;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                result_stall <= 1'b1;
                n = hold_cycles;
                hold_cycles = 0;
                repeat (n) @(posedge clk);
            end
            else if (rx_idle_on)
            begin
                n = $urandom_range(0, 17);
                if (n > 0)
                begin
                    result_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                result_stall <= 1'b0;
                @(posedge clk);
                while (!result_valid) @(posedge clk);
            end
            else
            begin
                result_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // tests
    task automatic test_extremes();
        begin
            send_point(32'h8000_0000, 32'h7fff_ffff, 1'b0);
            send_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
            send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
            send_point(32'hffff_ffff, 32'hffff_ffff, 1'b1);
            // single point set
            send_point(32'h0001_0000, 32'h8000_0000, 1'b1);
            // ties in x keep arrival order
            send_point(32'h0002_0000, 32'h0000_0001, 1'b0);
            send_point(32'h0002_0000, 32'h0000_0005, 1'b0);
            send_point(32'h0002_0000, 32'h0000_0002, 1'b0);
            send_point(32'h0002_0000, 32'h0000_0004, 1'b1);
            // all y equal: every point is at the mean
            send_point(32'h0000_0003, 32'h0000_0007, 1'b0);
            send_point(32'h0000_0001, 32'h0000_0007, 1'b0);
            send_point(32'h0000_0002, 32'h0000_0007, 1'b1);
            wait_drained();
        end
    endtask

    task automatic test_overflow();
        int i;
        begin
            for (i = 0; i < MAX_POINTS + 3; i++)
                send_point($urandom, $urandom, i == MAX_POINTS + 2);
            // full store exactly, no drop
            for (i = 0; i < MAX_POINTS; i++)
                send_point($urandom, $urandom, i == MAX_POINTS - 1);
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        begin
            hold_cycles = 400;
            send_set(20);
            send_set(10);
            wait_drained();
        end
    endtask

    task automatic test_random();
        int sent;
        int n;
        begin
            sent = 0;
            while (sent < 240)
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 66)
                                                 : $urandom_range(1, 8);
                send_set(n);
                sent += n;
            end
            wait_drained();
        end
    endtask

    initial
    begin
        error_count = 0;
        hold_cycles = 0;
        rx_idle_on = 1'b0;
        tx_idle_on = 1'b0;
        set_dropped = 1'b0;
        rst_n = 1'b0;
        point_valid = 1'b0;
        point = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_overflow();
        test_backpressure();
        rx_idle_on = 1'b1;
        tx_idle_on = 1'b1;
        test_extremes();
        test_random();
        if (error_count == 0 && ordered_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #(12 * 400000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- polygon_vertex_ordering.f -----
rtl/core/pvo_pkg.sv
rtl/core/pvo_front.sv
rtl/core/pvo_queue.sv
rtl/core/pvo_back.sv
rtl/core/polygon_vertex_ordering.sv
tb/tb.sv
